FILE: hw/rtl/olc_pkg.sv
// ----------------------------------------------------------------------------
// olc_pkg
// shared types and constants for the overstrike line composer
// ----------------------------------------------------------------------------
package olc_pkg;

    localparam int LINE_LEN = 256;
    localparam int AW       = $clog2(LINE_LEN);
    localparam int LW       = $clog2(LINE_LEN + 1);

    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic REQ_TEXT = 1'b0;
    localparam logic REQ_EOJ  = 1'b1;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_SPACE,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_CTRL,
        OP_EOJ
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [63:0] out_bytes_low;
        logic [63:0] out_bytes_high;
        logic [4:0]  byte_count;
        logic        last;
    } t_out;

endpackage

FILE: hw/rtl/olc_front.sv
// ----------------------------------------------------------------------------
// olc_front
// accepts input beats and classifies each byte into a command
// ----------------------------------------------------------------------------
module olc_front
    import olc_pkg::*;
(
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full
);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_cmd.ch = i_in_data.char_code;
        if (i_in_data.req_type == REQ_EOJ) begin
            o_cmd.op = OP_EOJ;
        end else if (i_in_data.char_code >= 8'h21 && i_in_data.char_code <= 8'h7E) begin
            o_cmd.op = OP_PRINT;
        end else if (i_in_data.char_code == CH_SP) begin
            o_cmd.op = OP_SPACE;
        end else if (i_in_data.char_code == CH_BS) begin
            o_cmd.op = OP_BS;
        end else if (i_in_data.char_code == CH_TAB) begin
            o_cmd.op = OP_TAB;
        end else if (i_in_data.char_code == CH_CR) begin
            o_cmd.op = OP_CR;
        end else begin
            o_cmd.op = OP_CTRL;
        end
    end

endmodule

FILE: hw/rtl/olc_queue.sv
// ----------------------------------------------------------------------------
// olc_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module olc_queue
    import olc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: hw/rtl/olc_back.sv
// ----------------------------------------------------------------------------
// olc_back
// executes commands on the two line stores and packs output bytes
// ----------------------------------------------------------------------------
module olc_back
    import olc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PRD, S_PDEC, S_PFILL, S_OFILL, S_FO_RD, S_FO_EM,
        S_FO_CR, S_FP_RD, S_FP_EM, S_CTL, S_END
    } t_state;

    t_state         r_st;
    logic [LW-1:0]  r_col, r_plen, r_olen, r_idx;
    logic [AW-1:0]  r_p;
    logic [7:0]     r_ch, r_mv, r_lastc;
    logic           r_ctl, r_ctx;
    logic [127:0]   r_pk;
    logic [4:0]     r_pk_cnt;
    logic           r_ov;
    t_out           r_out;

    logic [7:0]     prim [LINE_LEN];
    logic [7:0]     ovr  [LINE_LEN];
    logic [7:0]     r_prim_q, r_ovr_q;

    logic [AW-1:0]  rd_a, pw_a, ow_a;
    logic [7:0]     pw_d, ow_d;
    logic           pw_en, ow_en;
    logic           e_req, e_ok, out_free;
    logic [7:0]     e_byte;
    logic [LW-1:0]  p_ext;
    logic [LW:0]    tab_sum;

    assign p_ext    = LW'(r_p);
    assign out_free = !r_ov || i_out_ready;
    assign e_ok     = (r_pk_cnt != 5'd16) || out_free;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_pop    = (r_st == S_IDLE) && i_cmd_valid;
    assign tab_sum  = ({1'b0, r_col} + (LW+1)'(8)) & ~(LW+1)'(7);

    always_comb begin
        rd_a  = (r_st == S_PRD) ? r_col[AW-1:0] : r_idx[AW-1:0];
        pw_en = 1'b0;
        pw_a  = r_p;
        pw_d  = r_ch;
        ow_en = 1'b0;
        ow_a  = r_p;
        ow_d  = r_mv;
        if (r_st == S_PFILL) begin
            pw_en = 1'b1;
            if (r_plen < p_ext) begin
                pw_a = r_plen[AW-1:0];
                pw_d = CH_SP;
            end
        end
        if (r_st == S_OFILL) begin
            ow_en = 1'b1;
            if (r_olen < p_ext) begin
                ow_a = r_olen[AW-1:0];
                ow_d = CH_SP;
            end else begin
                pw_en = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_st)
            S_FO_EM: begin e_req = 1'b1; e_byte = r_ovr_q; end
            S_FP_EM: begin e_req = 1'b1; e_byte = r_prim_q; end
            S_FO_CR: begin e_req = 1'b1; e_byte = CH_CR; end
            S_CTL:   begin
                e_req  = !(r_ch == CH_FF && r_lastc == CH_FF);
                e_byte = r_ch;
            end
            default: begin e_req = 1'b0; e_byte = r_ch; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            prim[pw_a] <= pw_d;
        end
        r_prim_q <= prim[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (ow_en) begin
            ovr[ow_a] <= ow_d;
        end
        r_ovr_q <= ovr[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_col    <= '0;
            r_plen   <= '0;
            r_olen   <= '0;
            r_idx    <= '0;
            r_lastc  <= CH_FF;
            r_pk     <= '0;
            r_pk_cnt <= '0;
            r_ov     <= 1'b0;
            r_ctl    <= 1'b0;
            r_ctx    <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            // byte into the pack buffer, spilling a full buffer first
            if (e_req && e_ok) begin
                if (r_pk_cnt == 5'd16) begin
                    r_out <= '{r_pk[63:0], r_pk[127:64], 5'd16, 1'b0};
                    r_ov  <= 1'b1;
                    r_pk  <= {120'd0, e_byte};
                    r_pk_cnt <= 5'd1;
                end else begin
                    r_pk[r_pk_cnt[3:0]*8 +: 8] <= e_byte;
                    r_pk_cnt <= r_pk_cnt + 5'd1;
                end
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_ch <= i_cmd.ch;
                        unique case (i_cmd.op)
                            OP_PRINT: begin
                                if (r_col < LW'(LINE_LEN)) begin
                                    r_p  <= r_col[AW-1:0];
                                    r_st <= S_PRD;
                                end
                            end
                            OP_SPACE: begin
                                if (r_col < LW'(LINE_LEN)) r_col <= r_col + LW'(1);
                            end
                            OP_BS: begin
                                if (r_col != '0) r_col <= r_col - LW'(1);
                            end
                            OP_TAB: begin
                                if (tab_sum > (LW+1)'(LINE_LEN)) r_col <= LW'(LINE_LEN);
                                else r_col <= tab_sum[LW-1:0];
                            end
                            OP_CR: r_col <= '0;
                            OP_CTRL, OP_EOJ: begin
                                r_ctl <= (i_cmd.op == OP_CTRL);
                                r_ctx <= 1'b0;
                                r_idx <= '0;
                                r_st  <= S_FO_RD;
                            end
                            default: r_st <= S_IDLE;
                        endcase
                    end
                end
                S_PRD: r_st <= S_PDEC;
                S_PDEC: begin
                    r_mv <= r_prim_q;
                    if (p_ext >= r_plen || r_prim_q == CH_SP) begin
                        r_st <= S_PFILL;
                    end else if (p_ext < r_olen && r_ovr_q != CH_SP) begin
                        r_ctx <= 1'b1;
                        r_idx <= '0;
                        r_st  <= S_FO_RD;
                    end else begin
                        r_st <= S_OFILL;
                    end
                end
                S_PFILL: begin
                    if (r_plen < p_ext) begin
                        r_plen <= r_plen + LW'(1);
                    end else begin
                        if (r_plen == p_ext) r_plen <= p_ext + LW'(1);
                        r_col <= p_ext + LW'(1);
                        r_st  <= S_END;
                    end
                end
                S_OFILL: begin
                    if (r_olen < p_ext) begin
                        r_olen <= r_olen + LW'(1);
                    end else begin
                        if (r_olen == p_ext) r_olen <= p_ext + LW'(1);
                        r_col <= p_ext + LW'(1);
                        r_st  <= S_END;
                    end
                end
                S_FO_RD: begin
                    if (r_idx < r_olen) begin
                        r_st <= S_FO_EM;
                    end else if (r_olen != '0) begin
                        r_st <= S_FO_CR;
                    end else if (r_ctx) begin
                        r_st <= S_OFILL;
                    end else begin
                        r_idx <= '0;
                        r_st  <= S_FP_RD;
                    end
                end
                S_FO_EM: begin
                    if (e_ok) begin
                        r_idx <= r_idx + LW'(1);
                        r_st  <= S_FO_RD;
                    end
                end
                S_FO_CR: begin
                    if (e_ok) begin
                        r_lastc <= CH_CR;
                        r_olen  <= '0;
                        r_idx   <= '0;
                        r_st    <= r_ctx ? S_OFILL : S_FP_RD;
                    end
                end
                S_FP_RD: begin
                    if (r_idx < r_plen) begin
                        r_st <= S_FP_EM;
                    end else begin
                        r_plen <= '0;
                        r_col  <= '0;
                        r_st   <= r_ctl ? S_CTL : S_END;
                    end
                end
                S_FP_EM: begin
                    if (e_ok) begin
                        r_idx <= r_idx + LW'(1);
                        r_st  <= S_FP_RD;
                    end
                end
                S_CTL: begin
                    if (!e_req || e_ok) begin
                        r_lastc <= r_ch;
                        r_st    <= S_END;
                    end
                end
                S_END: begin
                    if (r_pk_cnt == 5'd0) begin
                        r_st <= S_IDLE;
                    end else if (out_free) begin
                        r_out    <= '{r_pk[63:0], r_pk[127:64], r_pk_cnt, 1'b1};
                        r_ov     <= 1'b1;
                        r_pk     <= '0;
                        r_pk_cnt <= 5'd0;
                        r_st     <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/overstrike_line_composer.sv
// printable bytes read both line stores, then pad any gap columns with spaces before storing
// flushes emit each stored byte in turn, and stall while results wait
// throughput: one cursor byte per cycle while the back sequencer is idle; prints and flushes hold it up
// reset: synchronous active low, clears column, lengths, queue and output;
// last control byte resets to form feed, line stores are not cleared
// ----------------------------------------------------------------------------
// overstrike_line_composer
// composes overstruck printer text into primary and overstrike lines
// ----------------------------------------------------------------------------
module overstrike_line_composer
    import olc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // front side: classify each beat
    logic q_push, q_full, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    olc_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (q_push),
        .o_cmd      (f_cmd),
        .i_full     (q_full)
    );

    // short two-entry queue so the front keeps taking beats while the back flushes, until it fills
    olc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // back side: line stores, flush sequencing and byte packing
    olc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.byte_count != 5'd0 && o_out_data.byte_count <= 5'd16))
        else $error("byte count out of range");
    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.byte_count == 5'd16))
        else $error("short beat without last");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_valid)
        else $error("input stalled with empty queue");
`endif

endmodule
